/* rtl/rpn_stack_calculator_macros.svh */
// Assertion macros for the reverse-Polish calculator.
// Included by the top level; expects clk and arst_n in scope.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define RPN_ASSERT_NOW(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define RPN_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rpn_pkg.sv */
// Shared constants and types for the reverse-Polish calculator.
// No dependencies; imported by rpn_muldiv and rpn_stack_calculator.
package rpn_pkg;

	localparam int DEF_STACK_DEPTH = 10;
	localparam int DEF_WORD_WIDTH  = 32;

	localparam logic [3:0] ACT_DIGIT   = 4'd0;
	localparam logic [3:0] ACT_EQUALS  = 4'd1;
	localparam logic [3:0] ACT_ADD     = 4'd2;
	localparam logic [3:0] ACT_SUB     = 4'd3;
	localparam logic [3:0] ACT_MUL     = 4'd4;
	localparam logic [3:0] ACT_DIV     = 4'd5;
	localparam logic [3:0] ACT_SIDE    = 4'd6;
	localparam logic [3:0] ACT_DOT     = 4'd7;
	localparam logic [3:0] ACT_RELEASE = 4'd8;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Reverse-Polish calculator: one key action per item, one result strobe per item.
// Digit, dot, release and other no-ops go from accept through S_RD_SHOW to the S_SHOW strobe.
// Equals, side button, add and subtract step through the stack memory reads before the result.
// Multiply and divide also wait on the shared one-bit-per-cycle unit, but a divide by
// zero does not. Reset clears the stack valid bits, pointer and entry at once.
module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         action,
	input  logic [3:0]         digit,
	output logic               done,
	output logic signed [31:0] shown_value,
	output logic               entry_pending,
	output logic               exit_request,
	output logic               redraw,
	output logic               divide_by_zero
);

	`include "rpn_stack_calculator_macros.svh"

	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_COMMIT  = 4'd1;
	localparam logic [3:0] S_RD_T    = 4'd2;
	localparam logic [3:0] S_GET_T   = 4'd3;
	localparam logic [3:0] S_GET_N   = 4'd4;
	localparam logic [3:0] S_EXEC    = 4'd5;
	localparam logic [3:0] S_WAIT    = 4'd6;
	localparam logic [3:0] S_PUSH    = 4'd7;
	localparam logic [3:0] S_RD_SHOW = 4'd8;
	localparam logic [3:0] S_SHOW    = 4'd9;

	logic [3:0]            state_q;
	logic [3:0]            act_q;
	logic [PTR_W-1:0]      tp_q;
	logic [WORD_WIDTH-1:0] entry_q;
	logic                  dirty_q;
	logic                  exit_q;
	logic                  dz_q;
	logic [WORD_WIDTH-1:0] t_q;
	logic [WORD_WIDTH-1:0] n_q;
	logic [WORD_WIDTH-1:0] res_q;

	logic [WORD_WIDTH-1:0] mem_q [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] vld_q;
	logic [WORD_WIDTH-1:0] rdata_q;
	logic                  rvld_q;

	logic [PTR_W-1:0]      tp_inc;
	logic [PTR_W-1:0]      tp_dec;
	logic [PTR_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [WORD_WIDTH-1:0] rword;
	logic                  is_arith;
	logic                  accept;

	md_req_t               md_req;
	logic                  md_done;
	logic [WORD_WIDTH-1:0] md_result;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign tp_inc   = (tp_q == PTR_LAST) ? '0 : tp_q + 1'b1;
	assign tp_dec   = (tp_q == '0) ? PTR_LAST : tp_q - 1'b1;
	assign is_arith = (act_q == ACT_ADD) || (act_q == ACT_SUB) ||
	                  (act_q == ACT_MUL) || (act_q == ACT_DIV);

	// The second operand sits one below the top; its read is issued while the top arrives.
	assign rd_addr = (state_q == S_GET_T) ? tp_dec : tp_q;
	assign wr_en   = (state_q == S_COMMIT) || (state_q == S_PUSH);
	assign wr_data = (state_q == S_COMMIT) ? entry_q : res_q;
	// An entry never written since reset reads as zero.
	assign rword   = rvld_q ? rdata_q : '0;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[tp_inc] <= wr_data;
		rdata_q <= mem_q[rd_addr];
		rvld_q  <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[tp_inc] <= 1'b1;
		end
	end

	assign md_req.start  = (state_q == S_EXEC) &&
	                       ((act_q == ACT_MUL) || ((act_q == ACT_DIV) && (t_q != '0)));
	assign md_req.is_div = (act_q == ACT_DIV);

	rpn_muldiv #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.opa    (n_q),
		.opb    (t_q),
		.done   (md_done),
		.result (md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= ACT_DOT;
			tp_q    <= '0;
			entry_q <= '0;
			dirty_q <= 1'b0;
			exit_q  <= 1'b0;
			dz_q    <= 1'b0;
			t_q     <= '0;
			n_q     <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q  <= action;
						exit_q <= 1'b0;
						dz_q   <= 1'b0;
						case (action)
							ACT_DIGIT: begin
								entry_q <= (entry_q << 3) + (entry_q << 1) +
								           WORD_WIDTH'(digit);
								dirty_q <= 1'b1;
								state_q <= S_RD_SHOW;
							end
							ACT_EQUALS, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SIDE: begin
								state_q <= dirty_q ? S_COMMIT : S_RD_T;
							end
							default: begin
								state_q <= S_RD_SHOW;
							end
						endcase
					end
				end
				S_COMMIT: begin
					tp_q    <= tp_inc;
					entry_q <= '0;
					dirty_q <= 1'b0;
					state_q <= is_arith ? S_RD_T : S_RD_SHOW;
				end
				S_RD_T: begin
					state_q <= S_GET_T;
				end
				S_GET_T: begin
					t_q <= rword;
					if (is_arith) begin
						tp_q    <= tp_dec;
						state_q <= S_GET_N;
					end else if (act_q == ACT_SIDE) begin
						res_q <= '0;
						if (rword == '0) begin
							exit_q  <= 1'b1;
							state_q <= S_RD_SHOW;
						end else begin
							state_q <= S_PUSH;
						end
					end else begin
						// Equals with nothing pending duplicates the top.
						res_q   <= rword;
						state_q <= S_PUSH;
					end
				end
				S_GET_N: begin
					n_q     <= rword;
					tp_q    <= tp_dec;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (act_q)
						ACT_ADD: begin
							res_q   <= n_q + t_q;
							state_q <= S_PUSH;
						end
						ACT_SUB: begin
							res_q   <= n_q - t_q;
							state_q <= S_PUSH;
						end
						ACT_DIV: begin
							if (t_q == '0) begin
								res_q   <= '0;
								dz_q    <= 1'b1;
								state_q <= S_PUSH;
							end else begin
								state_q <= S_WAIT;
							end
						end
						default: begin
							state_q <= S_WAIT;
						end
					endcase
				end
				S_WAIT: begin
					if (md_done) begin
						res_q   <= md_result;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					tp_q    <= tp_inc;
					state_q <= S_RD_SHOW;
				end
				S_RD_SHOW: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic signed [WORD_WIDTH-1:0] shown_word;

	assign shown_word     = dirty_q ? entry_q : rword;
	assign done           = (state_q == S_SHOW);
	assign shown_value    = 32'(shown_word);
	assign entry_pending  = dirty_q;
	assign exit_request   = exit_q;
	assign redraw         = (act_q != ACT_RELEASE);
	assign divide_by_zero = dz_q;

	`RPN_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not make the block busy")
	`RPN_ASSERT_NEXT(a_done_idle, done, !busy, "block stayed busy after its result strobe")
	`RPN_ASSERT_NOW(a_exit_zero, done && exit_request, (shown_value == 32'sd0) && !entry_pending, "exit request without a zero top and clean entry")
	`RPN_ASSERT_NOW(a_dz_divide, done && divide_by_zero, (act_q == ACT_DIV) && (shown_value == 32'sd0), "divide by zero flag on a result that is not a zero quotient")

endmodule

/* rtl/rpn_muldiv.sv */
// Shared iterative multiply / signed divide unit, one bit per cycle.
// Depends on rpn_pkg (md_req_t, DEF_WORD_WIDTH).
module rpn_muldiv import rpn_pkg::*; #(
	parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  md_req_t               req,
	input  logic [WORD_WIDTH-1:0] opa,
	input  logic [WORD_WIDTH-1:0] opb,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] result
);

	localparam int CNT_W = $clog2(WORD_WIDTH + 1);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_RUN  = 2'd1;
	localparam logic [1:0] U_FIN  = 2'd2;

	logic [1:0]            st_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  div_q;
	logic                  neg_q;
	logic [WORD_WIDTH-1:0] a_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [WORD_WIDTH:0]   r_q;

	logic [WORD_WIDTH:0]   rs;
	logic [WORD_WIDTH:0]   op_x;
	logic [WORD_WIDTH:0]   op_y;
	logic [WORD_WIDTH:0]   sum;
	logic [WORD_WIDTH-1:0] abs_a;
	logic [WORD_WIDTH-1:0] abs_b;

	// One adder serves both: accumulate for multiply, trial subtract for divide.
	assign rs   = {r_q[WORD_WIDTH-1:0], a_q[WORD_WIDTH-1]};
	assign op_x = div_q ? rs : r_q;
	assign op_y = div_q ? {1'b0, b_q} : {1'b0, a_q};
	assign sum  = op_x + (op_y ^ {(WORD_WIDTH+1){div_q}}) + (WORD_WIDTH+1)'(div_q);

	assign abs_a = opa[WORD_WIDTH-1] ? (~opa + 1'b1) : opa;
	assign abs_b = opb[WORD_WIDTH-1] ? (~opb + 1'b1) : opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= U_IDLE;
		end else begin
			case (st_q)
				U_IDLE: begin
					if (req.start) st_q <= U_RUN;
				end
				U_RUN: begin
					if (cnt_q == CNT_W'(1)) st_q <= U_FIN;
				end
				U_FIN: begin
					st_q <= U_IDLE;
				end
				default: begin
					st_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == U_IDLE && req.start) begin
			cnt_q <= CNT_W'(WORD_WIDTH);
			div_q <= req.is_div;
			r_q   <= '0;
			if (req.is_div) begin
				a_q   <= abs_a;
				b_q   <= abs_b;
				neg_q <= opa[WORD_WIDTH-1] ^ opb[WORD_WIDTH-1];
			end else begin
				a_q   <= opa;
				b_q   <= opb;
				neg_q <= 1'b0;
			end
		end else if (st_q == U_RUN) begin
			cnt_q <= cnt_q - 1'b1;
			if (div_q) begin
				// Restoring step: keep the difference when it did not go negative.
				if (!sum[WORD_WIDTH]) begin
					r_q <= sum;
					a_q <= {a_q[WORD_WIDTH-2:0], 1'b1};
				end else begin
					r_q <= rs;
					a_q <= {a_q[WORD_WIDTH-2:0], 1'b0};
				end
			end else begin
				if (b_q[0]) r_q <= sum;
				a_q <= {a_q[WORD_WIDTH-2:0], 1'b0};
				b_q <= {1'b0, b_q[WORD_WIDTH-1:1]};
			end
		end
	end

	assign done   = (st_q == U_FIN);
	assign result = div_q ? (neg_q ? (~a_q + 1'b1) : a_q) : r_q[WORD_WIDTH-1:0];

endmodule
